// ===== sv/psesc_pkg.sv =====
// ----------------------------------------------------------------------------
// psesc_pkg
// Shared constants and types for the periodic sample event scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package psesc_pkg;

	// Default configuration of the scheduler.
	localparam int PSESC_CHANNELS  = 8;
	localparam int PSESC_TIME_BITS = 48;

	// Fixed widths of the item fields on the ports.
	localparam int FIELD_TIME_BITS  = 48;
	localparam int FIELD_MODE_BITS  = 2;
	localparam int FIELD_CHAN_BITS  = 3;
	localparam int FIELD_MASK_BITS  = 8;
	localparam int FIELD_COUNT_BITS = 32;
	localparam int TOL_BITS         = 16;
	localparam int CHANS_BITS       = 4;
	localparam int CFG_DATA_BITS    = 16;
	localparam int CFG_INDEX_BITS   = 1;

	// Item modes.
	localparam logic [FIELD_MODE_BITS-1:0] MODE_LOAD   = 2'd0;
	localparam logic [FIELD_MODE_BITS-1:0] MODE_CHECK  = 2'd1;
	localparam logic [FIELD_MODE_BITS-1:0] MODE_HANDLE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNELS  = 1'b1;

	// Control of one channel cell.
	typedef struct packed {
		logic shift;
		logic load;
	} psesc_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/psesc_cell.sv =====
// ----------------------------------------------------------------------------
// psesc_cell
// One channel cell: holds a due time and an interval, loads from the item
// or takes its neighbor's contents when the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module psesc_cell
	import psesc_pkg::*;
#(
	parameter int TIME_BITS = PSESC_TIME_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire psesc_cell_ctrl_t     ctrl,
	input  wire logic [TIME_BITS-1:0] shift_due,
	input  wire logic [TIME_BITS-1:0] shift_per,
	input  wire logic [TIME_BITS-1:0] load_due,
	input  wire logic [TIME_BITS-1:0] load_per,
	output logic      [TIME_BITS-1:0] due,
	output logic      [TIME_BITS-1:0] per
);

	logic [TIME_BITS-1:0] due_q;
	logic [TIME_BITS-1:0] per_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q <= '0;
			per_q <= '0;
		end else if (ctrl.load) begin
			due_q <= load_due;
			per_q <= load_per;
		end else if (ctrl.shift) begin
			due_q <= shift_due;
			per_q <= shift_per;
		end
	end

	assign due = due_q;
	assign per = per_q;

endmodule

`default_nettype wire

// ===== sv/psesc_head.sv =====
// ----------------------------------------------------------------------------
// psesc_head
// Fire decision at the head of the ring: judges the head channel due and
// advances its due time by its interval, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module psesc_head
	import psesc_pkg::*;
#(
	parameter int TIME_BITS = PSESC_TIME_BITS
) (
	input  wire logic                 fire_en,
	input  wire logic [TIME_BITS-1:0] due,
	input  wire logic [TIME_BITS-1:0] per,
	input  wire logic [TIME_BITS-1:0] limit,
	output logic                      fire,
	output logic      [TIME_BITS-1:0] due_next
);

	logic [TIME_BITS:0]   sum;
	logic [TIME_BITS-1:0] advanced;

	always_comb begin
		sum      = {1'b0, due} + {1'b0, per};
		advanced = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
		fire     = fire_en && (due <= limit);
		due_next = fire ? advanced : due;
	end

endmodule

`default_nettype wire

// ===== sv/periodic_sample_event_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_sample_event_scheduler
// Multi-channel periodic timer scheduler with step clamping and event firing.
// ----------------------------------------------------------------------------
// Channels live in a ring of CHANNELS cells. A load or an armed handle
// rotates the ring once through the head unit, one channel per cycle, which
// fires and advances due channels for a handle and rebuilds the earliest due
// time. Such an item passes the states EXEC, WALK and FINISH before the next
// item can be accepted; a check, an unarmed handle or an unused mode skips WALK.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted.
`default_nettype none

module periodic_sample_event_scheduler
	import psesc_pkg::*;
#(
	parameter int CHANNELS  = PSESC_CHANNELS,
	parameter int TIME_BITS = PSESC_TIME_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [FIELD_MODE_BITS-1:0]  mode,
	input  wire logic [FIELD_CHAN_BITS-1:0]  channel,
	input  wire logic [FIELD_TIME_BITS-1:0]  start_time,
	input  wire logic [FIELD_TIME_BITS-1:0]  period,
	input  wire logic [FIELD_TIME_BITS-1:0]  current_time,
	input  wire logic [FIELD_TIME_BITS-1:0]  proposed_step,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [FIELD_TIME_BITS-1:0]  step_out,
	output logic                             armed,
	output logic      [FIELD_MASK_BITS-1:0]  fired_mask,
	output logic      [FIELD_TIME_BITS-1:0]  next_due,
	output logic      [FIELD_COUNT_BITS-1:0] fired_total
);

	localparam int KW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_WALK   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]                  state_q;
	logic [KW-1:0]               k_q;
	logic [TOL_BITS-1:0]         tol_q;
	logic [CHANS_BITS-1:0]       chans_q;
	logic [TIME_BITS-1:0]        earliest_q;
	logic                        armed_q;
	logic [FIELD_COUNT_BITS-1:0] count_q;
	logic [FIELD_MASK_BITS-1:0]  mask_q;
	logic [TIME_BITS-1:0]        step_res_q;
	logic [TIME_BITS-1:0]        limit_q;

	logic [FIELD_MODE_BITS-1:0]  mode_q;
	logic [FIELD_CHAN_BITS-1:0]  ch_q;
	logic [TIME_BITS-1:0]        start_q;
	logic [TIME_BITS-1:0]        per_q;
	logic [TIME_BITS-1:0]        now_q;
	logic [TIME_BITS-1:0]        step_q;

	logic                        out_valid_q;
	logic [FIELD_TIME_BITS-1:0]  out_step_q;
	logic                        out_armed_q;
	logic [FIELD_MASK_BITS-1:0]  out_mask_q;
	logic [FIELD_TIME_BITS-1:0]  out_due_q;
	logic [FIELD_COUNT_BITS-1:0] out_total_q;

	logic [TIME_BITS+1:0]        reach_sum;
	logic [TIME_BITS-1:0]        reach;
	logic [TIME_BITS:0]          limit_sum;
	logic [TIME_BITS-1:0]        limit;
	logic                        hit;
	logic [TIME_BITS-1:0]        gap;
	logic                        walking;
	logic                        active;
	logic                        last;
	logic                        out_free;

	logic [TIME_BITS-1:0]        cell_due [CHANNELS];
	logic [TIME_BITS-1:0]        cell_per [CHANNELS];
	logic                        head_fire;
	logic [TIME_BITS-1:0]        head_due_next;

	assign in_ready = (state_q == ST_IDLE);
	assign walking  = (state_q == ST_WALK);
	assign active   = (32'(k_q) < 32'(chans_q));
	assign last     = (k_q == KW'(CHANNELS - 1));
	assign out_free = !out_valid_q || out_ready;

	// The end of the step plus the tolerance, and the due limit for a handle.
	always_comb begin
		reach_sum = {2'b00, now_q} + {2'b00, step_q} + (TIME_BITS + 2)'(tol_q);
		reach     = (reach_sum[TIME_BITS+1:TIME_BITS] != 2'b00) ? '1
		            : reach_sum[TIME_BITS-1:0];
		limit_sum = {1'b0, now_q} + (TIME_BITS + 1)'(tol_q);
		limit     = limit_sum[TIME_BITS] ? '1 : limit_sum[TIME_BITS-1:0];
		hit       = (earliest_q <= reach) && (earliest_q >= now_q);
		gap       = earliest_q - now_q;
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		psesc_cell_ctrl_t     ctrl;
		logic [TIME_BITS-1:0] sh_due;
		logic [TIME_BITS-1:0] sh_per;

		assign ctrl.shift = walking;
		assign ctrl.load  = (state_q == ST_EXEC) && (mode_q == MODE_LOAD)
		                    && (32'(ch_q) == i);

		// The tail cell takes the head channel back after the head unit.
		if (i == CHANNELS - 1) begin : g_tail
			assign sh_due = head_due_next;
			assign sh_per = cell_per[0];
		end else begin : g_mid
			assign sh_due = cell_due[i+1];
			assign sh_per = cell_per[i+1];
		end

		psesc_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.shift_due (sh_due),
			.shift_per (sh_per),
			.load_due  (start_q),
			.load_per  (per_q),
			.due       (cell_due[i]),
			.per       (cell_per[i])
		);
	end

	psesc_head #(
		.TIME_BITS (TIME_BITS)
	) u_head (
		.fire_en  (walking && (mode_q == MODE_HANDLE) && active),
		.due      (cell_due[0]),
		.per      (cell_per[0]),
		.limit    (limit_q),
		.fire     (head_fire),
		.due_next (head_due_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= '0;
			chans_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOLERANCE: tol_q   <= cfg_data;
				CFG_CHANNELS:  chans_q <= cfg_data[CHANS_BITS-1:0];
			endcase
		end
	end

	// The item fields are held for the whole of its work.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q  <= mode;
			ch_q    <= channel;
			start_q <= TIME_BITS'(start_time);
			per_q   <= TIME_BITS'(period);
			now_q   <= TIME_BITS'(current_time);
			step_q  <= TIME_BITS'(proposed_step);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			earliest_q <= '1;
			armed_q    <= 1'b0;
			count_q    <= '0;
			mask_q     <= '0;
			step_res_q <= '0;
			limit_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					k_q        <= '0;
					mask_q     <= '0;
					step_res_q <= '0;
					state_q    <= ST_FINISH;
					unique case (mode_q)
						MODE_LOAD: begin
							state_q <= ST_WALK;
						end
						MODE_CHECK: begin
							step_res_q <= step_q;
							if (hit) begin
								step_res_q <= gap;
								armed_q    <= 1'b1;
							end
						end
						MODE_HANDLE: begin
							if (armed_q) begin
								limit_q <= limit;
								state_q <= ST_WALK;
							end
						end
						default: begin
						end
					endcase
				end
				ST_WALK: begin
					k_q <= k_q + 1'b1;
					// With no channels in use the earliest due time stays.
					if (active && ((k_q == '0) || (head_due_next < earliest_q))) begin
						earliest_q <= head_due_next;
					end
					for (int b = 0; b < FIELD_MASK_BITS; b++) begin
						if (head_fire && (32'(k_q) == b)) begin
							mask_q[b] <= 1'b1;
						end
					end
					if (last) begin
						state_q <= ST_FINISH;
						if (mode_q == MODE_HANDLE) begin
							armed_q <= 1'b0;
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			out_step_q  <= FIELD_TIME_BITS'(step_res_q);
			out_armed_q <= armed_q;
			out_mask_q  <= mask_q;
			out_due_q   <= FIELD_TIME_BITS'(earliest_q);
			out_total_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign step_out    = out_step_q;
	assign armed       = out_armed_q;
	assign fired_mask  = out_mask_q;
	assign next_due    = out_due_q;
	assign fired_total = out_total_q;

endmodule

`default_nettype wire

// ===== tb/periodic_sample_event_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// periodic_sample_event_scheduler_test
// Self-checking testbench for the periodic sample event scheduler. A mirror of
// the channel table predicts one report per accepted item, and every report
// the block sends is compared field by field with the oldest prediction.
// Directed items come first, then random load, check and handle sequences
// under several register settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_sample_event_scheduler_test;
	import psesc_pkg::*;

	localparam int CHANNELS = PSESC_CHANNELS;
	localparam logic [FIELD_MODE_BITS-1:0] MODE_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;

	typedef logic [FIELD_TIME_BITS-1:0] tval_t;
	localparam tval_t TIME_MAX = '1;

	typedef struct packed {
		logic [FIELD_MODE_BITS-1:0] mode;
		logic [FIELD_CHAN_BITS-1:0] channel;
		tval_t                      start_time;
		tval_t                      period;
		tval_t                      current_time;
		tval_t                      proposed_step;
	} sched_item_t;

	typedef struct packed {
		tval_t                       step_out;
		logic                        armed;
		logic [FIELD_MASK_BITS-1:0]  fired_mask;
		tval_t                       next_due;
		logic [FIELD_COUNT_BITS-1:0] fired_total;
	} sched_report_t;

	// Mirror of the channel table; predicts the report of every accepted item.
	class schedule_mirror;
		tval_t                       due[CHANNELS];
		tval_t                       per[CHANNELS];
		tval_t                       earliest;
		logic                        armed_q;
		logic [FIELD_COUNT_BITS-1:0] events;
		logic [TOL_BITS-1:0]         tolerance;
		logic [CHANS_BITS-1:0]       active;
		sched_report_t               expected_reports[$];
		int                          failures;

		function new();
			for (int i = 0; i < CHANNELS; i++) begin
				due[i] = '0;
				per[i] = '0;
			end
			earliest  = TIME_MAX;
			armed_q   = 1'b0;
			events    = '0;
			tolerance = '0;
			active    = '0;
			failures  = 0;
		endfunction

		function tval_t sat_add(tval_t a, tval_t b);
			logic [FIELD_TIME_BITS:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[FIELD_TIME_BITS] ? TIME_MAX : s[FIELD_TIME_BITS-1:0];
		endfunction

		function void refresh_earliest(int n);
			for (int i = 0; i < n; i++)
				if (i == 0 || due[i] < earliest)
					earliest = due[i];
		endfunction

		function void write_register(logic [CFG_INDEX_BITS-1:0] idx,
				logic [CFG_DATA_BITS-1:0] data);
			if (idx == CFG_TOLERANCE)
				tolerance = data[TOL_BITS-1:0];
			else
				active = data[CHANS_BITS-1:0];
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void take_item(sched_item_t it);
			sched_report_t r;
			tval_t         limit;
			int            n;
			r = '0;
			n = (int'(active) > CHANNELS) ? CHANNELS : int'(active);
			case (it.mode)
				MODE_LOAD: begin
					due[it.channel] = it.start_time;
					per[it.channel] = it.period;
					refresh_earliest(n);
				end
				MODE_CHECK: begin
					r.step_out = it.proposed_step;
					limit = sat_add(sat_add(it.current_time, it.proposed_step),
						tval_t'(tolerance));
					if (earliest <= limit && earliest >= it.current_time) begin
						r.step_out = earliest - it.current_time;
						armed_q = 1'b1;
					end
				end
				MODE_HANDLE: begin
					if (armed_q) begin
						limit = sat_add(it.current_time, tval_t'(tolerance));
						for (int i = 0; i < n; i++) begin
							if (due[i] <= limit) begin
								r.fired_mask[i] = 1'b1;
								due[i] = sat_add(due[i], per[i]);
							end
						end
						refresh_earliest(n);
						armed_q = 1'b0;
						events = events + 1'b1;
					end
				end
				default: ;
			endcase
			r.armed       = armed_q;
			r.next_due    = earliest;
			r.fired_total = events;
			expected_reports.push_back(r);
		endfunction

		function void note_failure(string what, logic [63:0] want, logic [63:0] got);
			failures++;
			if (failures <= 10)
				$display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, what, want, got);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got)
				note_failure(name, want, got);
		endfunction

		function void compare_report(sched_report_t got);
			sched_report_t want;
			if (expected_reports.size() == 0) begin
				note_failure("unexpected report, step_out", '0, 64'(got.step_out));
				return;
			end
			want = expected_reports.pop_front();
			compare_field("step_out", 64'(want.step_out), 64'(got.step_out));
			compare_field("armed", 64'(want.armed), 64'(got.armed));
			compare_field("fired_mask", 64'(want.fired_mask), 64'(got.fired_mask));
			compare_field("next_due", 64'(want.next_due), 64'(got.next_due));
			compare_field("fired_total", 64'(want.fired_total), 64'(got.fired_total));
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [CFG_INDEX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]    cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic [FIELD_MODE_BITS-1:0]  mode;
	logic [FIELD_CHAN_BITS-1:0]  channel;
	tval_t                       start_time;
	tval_t                       period;
	tval_t                       current_time;
	tval_t                       proposed_step;
	logic                        out_valid;
	logic                        out_ready;
	tval_t                       step_out;
	logic                        armed;
	logic [FIELD_MASK_BITS-1:0]  fired_mask;
	tval_t                       next_due;
	logic [FIELD_COUNT_BITS-1:0] fired_total;

	schedule_mirror sb;
	tval_t          scene_now;
	int             idle_pct;
	int             stall_pct;
	bit             hold_request;

	periodic_sample_event_scheduler u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic tval_t rand_time();
		return {16'($urandom), $urandom};
	endfunction

	function automatic sched_item_t mk_item(logic [FIELD_MODE_BITS-1:0] m, int ch,
			tval_t st, tval_t pr, tval_t now, tval_t stp);
		sched_item_t it;
		it.mode          = m;
		it.channel       = 3'(ch);
		it.start_time    = st;
		it.period        = pr;
		it.current_time  = now;
		it.proposed_step = stp;
		return it;
	endfunction

	task automatic send_item(input sched_item_t it);
		int gap;
		gap = 0;
		while (gap < 40 && int'($urandom_range(99)) < idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode          <= it.mode;
		channel       <= it.channel;
		start_time    <= it.start_time;
		period        <= it.period;
		current_time  <= it.current_time;
		proposed_step <= it.proposed_step;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.take_item(it);
	endtask

	// Stops offering items and waits until every predicted report has come.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_register(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed load, check and handle items that follow the
	// predicted earliest due time, with some random noise mixed in.
	task automatic make_random_item(output sched_item_t it);
		int unsigned pick;
		int unsigned j;
		tval_t       reach;
		it.mode          = MODE_UNUSED;
		it.channel       = 3'($urandom_range(7));
		it.start_time    = rand_time();
		it.period        = rand_time();
		it.current_time  = rand_time();
		it.proposed_step = rand_time();
		pick = $urandom_range(99);
		if (pick < 22) begin
			it.mode = MODE_LOAD;
			if ($urandom_range(9) != 0)
				it.start_time = sb.sat_add(scene_now, tval_t'($urandom_range(200000)));
			case ($urandom_range(9))
				0: it.period = '0;
				1: it.period = TIME_MAX;
				2: ;
				default: it.period = tval_t'($urandom_range(1 << 18, 1));
			endcase
		end else if (pick < 60) begin
			it.mode = MODE_CHECK;
			it.current_time = scene_now;
			if (sb.earliest >= scene_now && $urandom_range(3) != 0) begin
				reach = sb.earliest - scene_now;
				j = $urandom_range(80000);
				if ($urandom_range(1) == 0)
					it.proposed_step = sb.sat_add(reach, tval_t'($urandom_range(1000)));
				else
					it.proposed_step = (reach > tval_t'(j)) ? reach - tval_t'(j) : '0;
			end else if ($urandom_range(1) == 0) begin
				it.proposed_step = tval_t'($urandom_range(300000));
			end
		end else if (pick < 92) begin
			it.mode = MODE_HANDLE;
			if (sb.armed_q && sb.earliest >= scene_now) begin
				j = $urandom_range(70000);
				if ($urandom_range(1) == 0 && sb.earliest > tval_t'(j))
					scene_now = sb.earliest - tval_t'(j);
				else
					scene_now = sb.earliest;
			end else begin
				scene_now = sb.sat_add(scene_now, tval_t'($urandom_range(5000)));
			end
			it.current_time = scene_now;
		end else begin
			it.mode = 2'($urandom_range(3));
			if ($urandom_range(1) == 0)
				scene_now = tval_t'($urandom_range(100000));
		end
	endtask

	// Receiver: checks every report and applies back pressure.
	initial begin : receiver
		sched_report_t got;
		int            hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.step_out    = step_out;
				got.armed       = armed;
				got.fired_mask  = fired_mask;
				got.next_due    = next_due;
				got.fired_total = fired_total;
				sb.compare_report(got);
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (int'($urandom_range(99)) >= stall_pct);
			end
		end
	end

	initial begin : stimulus
		sched_item_t it;
		sb = new();
		scene_now    = '0;
		idle_pct     = 14;
		stall_pct    = 14;
		hold_request = 1'b0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_TOLERANCE;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		mode          <= MODE_LOAD;
		channel       <= '0;
		start_time    <= '0;
		period        <= '0;
		current_time  <= '0;
		proposed_step <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// No channels in use: loads leave the earliest due time alone, and an
		// armed handle still counts an event.
		send_item(mk_item(MODE_CHECK, 0, rand_time(), rand_time(), '0, '0));
		send_item(mk_item(MODE_HANDLE, 0, rand_time(), rand_time(), '0, rand_time()));
		send_item(mk_item(MODE_UNUSED, 3, rand_time(), rand_time(), rand_time(),
			rand_time()));
		send_item(mk_item(MODE_LOAD, 5, 48'd100, 48'd10, rand_time(), rand_time()));
		send_item(mk_item(MODE_CHECK, 0, rand_time(), rand_time(), '0, TIME_MAX));
		send_item(mk_item(MODE_HANDLE, 0, rand_time(), rand_time(), '0, rand_time()));
		drain();
		// Upper data bits must be dropped by the channel count register.
		write_cfg(CFG_CHANNELS, 16'hFFF8);
		write_cfg(CFG_TOLERANCE, '0);

		send_item(mk_item(MODE_LOAD, 0, 48'd1000, 48'd500, '0, '0));
		send_item(mk_item(MODE_LOAD, 1, 48'd1000, TIME_MAX, '0, '0));
		send_item(mk_item(MODE_LOAD, 2, TIME_MAX, TIME_MAX, '0, '0));
		send_item(mk_item(MODE_LOAD, 3, 48'd3000, '0, '0, '0));
		send_item(mk_item(MODE_LOAD, 4, 48'd2000, 48'd1, '0, '0));
		send_item(mk_item(MODE_LOAD, 5, 48'd1500, 48'd700, '0, '0));
		send_item(mk_item(MODE_LOAD, 6, TIME_MAX - 48'd5, 48'd3, '0, '0));
		send_item(mk_item(MODE_LOAD, 7, 48'd4000, 48'd250, '0, '0));
		send_item(mk_item(MODE_CHECK, 0, '0, '0, '0, 48'd500));
		send_item(mk_item(MODE_CHECK, 0, '0, '0, 48'd2000, 48'd10));
		send_item(mk_item(MODE_CHECK, 0, '0, '0, '0, 48'd999));
		send_item(mk_item(MODE_CHECK, 0, '0, '0, '0, 48'd1000));
		send_item(mk_item(MODE_HANDLE, 0, '0, '0, 48'd1000, '0));
		send_item(mk_item(MODE_HANDLE, 0, '0, '0, 48'd5000, '0));
		send_item(mk_item(MODE_CHECK, 0, '0, '0, TIME_MAX, TIME_MAX));
		send_item(mk_item(MODE_UNUSED, 7, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX));
		drain();
		// Widest tolerance and a channel count above the table size.
		write_cfg(CFG_TOLERANCE, 16'hFFFF);
		write_cfg(CFG_CHANNELS, 16'd15);
		send_item(mk_item(MODE_CHECK, 0, '0, '0, '0, '0));
		send_item(mk_item(MODE_HANDLE, 0, '0, '0, '0, '0));
		send_item(mk_item(MODE_CHECK, 0, '0, '0, TIME_MAX - 48'd70000, '0));
		send_item(mk_item(MODE_HANDLE, 0, '0, '0, TIME_MAX, '0));

		for (int seg = 0; seg < 8; seg++) begin
			drain();
			case (seg)
				0: write_cfg(CFG_TOLERANCE, '0);
				1: write_cfg(CFG_TOLERANCE, 16'hFFFF);
				2: write_cfg(CFG_TOLERANCE, 16'd1000);
				default: write_cfg(CFG_TOLERANCE, 16'($urandom));
			endcase
			case (seg)
				0, 6: write_cfg(CFG_CHANNELS, {12'($urandom), 4'd8});
				1: write_cfg(CFG_CHANNELS, 16'd15);
				2: write_cfg(CFG_CHANNELS, 16'd3);
				3: write_cfg(CFG_CHANNELS, 16'd0);
				4: write_cfg(CFG_CHANNELS, 16'd1);
				default: write_cfg(CFG_CHANNELS, {12'($urandom), 4'($urandom_range(15))});
			endcase
			case (seg % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 65; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 65; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			for (int k = 0; k < 104; k++) begin
				// A long receiver hold while the sender keeps offering items.
				if (seg == 2 && k == 10)
					hold_request = 1'b1;
				if (seg == 5 && k == 50)
					drain();
				make_random_item(it);
				send_item(it);
			end
		end

		drain();
		repeat (CHANNELS + 4) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
